// File: hdl/bksp_pkg.sv
// bksp_pkg: shared types and codes for the best-k score pool.
// No dependencies; imported by best_k_score_pool and bksp_mod.
`timescale 1ns / 1ps

package bksp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_MOD,
		ST_PICK_RD,
		ST_PICK_DATA,
		ST_FINISH
	} state_t;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_PICK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] OUT_REJECT  = 2'd0;
	localparam logic [1:0] OUT_APPEND  = 2'd1;
	localparam logic [1:0] OUT_REPLACE = 2'd2;
	localparam logic [1:0] OUT_NONE    = 2'd3;

	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVATION = 1'b1;

	localparam int MODE_BITS  = 2;
	localparam int FIELD_BITS = 16;
	localparam int RND_BITS   = 32;
	localparam int CAP_BITS   = 5;
	localparam int ACT_BITS   = 16;
	localparam int OCC_BITS   = 5;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

// File: hdl/best_k_score_pool.sv
// best_k_score_pool: pool of the lowest-score (score, tag) entries with
// replace-worst and random pick. Depends on bksp_pkg and bksp_mod.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid / in_stall) carries one transaction: mode, score,
//  walk_tag, random_word. Output channel (out_valid / out_stall) returns one
//  result per transaction: add_outcome, picked_tag, picked_start, occupancy.
//  One transaction is in work at a time; in_stall is high until it is done.
//  Path per transaction, accept to output register:
//   add that appends or is rejected, clear, unused mode: straight to finish
//   add that replaces the worst: a rescan of the occupied slots for the new
//     worst, one pool read per cycle through the single memory read port
//   pick from the pool: the bit-serial remainder, then a tag read
//   pick that starts from scratch: straight to finish
//  A finished result sits in the output register; while the receiver stalls
//  a new transaction is still accepted and worked on, and its result waits
//  for the register to free up. Config (cfg_we/cfg_index/cfg_data) must be written only
//  while idle; the block does not enforce it. Reset empties the pool, zeroes the
//  offer count, sets capacity 16 and activation level 0; pool memory is not cleared.
module best_k_score_pool #(
	parameter int POOL_DEPTH = 16,
	parameter int SCORE_BITS = 16,
	parameter int TAG_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bksp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bksp_pkg::ACT_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bksp_pkg::MODE_BITS-1:0]    mode,
	input  logic [bksp_pkg::FIELD_BITS-1:0]   score,
	input  logic [bksp_pkg::FIELD_BITS-1:0]   walk_tag,
	input  logic [bksp_pkg::RND_BITS-1:0]     random_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        add_outcome,
	output logic [bksp_pkg::FIELD_BITS-1:0]   picked_tag,
	output logic                              picked_start,
	output logic [bksp_pkg::OCC_BITS-1:0]     occupancy
);
	import bksp_pkg::*;

	localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W = $clog2(POOL_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
	localparam logic [31:0] SCORE_MAX = 32'hFFFF_FFFF >> (32 - SCORE_BITS);

	state_t state_q, state_d;

	logic [CAP_BITS-1:0]   cap_q;
	logic [ACT_BITS-1:0]   act_q;
	logic [CNT_W-1:0]      count_q;
	logic [SCORE_BITS-1:0] worst_score_q;
	logic [AW-1:0]         worst_slot_q;
	logic [ACT_BITS-1:0]   offer_q;

	logic [1:0]            outcome_q;
	logic                  pstart_q;
	logic [TAG_BITS-1:0]   ptag_q;

	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  cmp_vld_s1;
	logic [AW-1:0]         cmp_idx_s1;

	logic [SCORE_BITS-1:0] score_mem [POOL_DEPTH];
	logic [TAG_BITS-1:0]   tag_mem [POOL_DEPTH];
	logic [SCORE_BITS-1:0] score_rd_q;
	logic [TAG_BITS-1:0]   tag_rd_q;

	logic                  out_valid_q;
	logic [1:0]            add_outcome_q;
	logic [FIELD_BITS-1:0] picked_tag_q;
	logic                  picked_start_q;
	logic [OCC_BITS-1:0]   occupancy_q;

	logic                  in_acc;
	logic [31:0]           score_ext;
	logic [SCORE_BITS-1:0] score_sat;
	logic [TAG_BITS-1:0]   tag_in;
	logic [CAP_BITS-1:0]   cap_eff;
	logic                  has_room;
	logic                  beats_worst;
	logic                  pick_start;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic                  mod_start;
	logic                  mod_done;
	logic [CNT_W-1:0]      mod_rem;
	logic                  out_load;

	assign in_acc      = in_valid && !in_stall;
	assign score_ext   = 32'(score);
	assign score_sat   = SCORE_BITS'((score_ext > SCORE_MAX) ? SCORE_MAX : score_ext);
	assign tag_in      = TAG_BITS'(32'(walk_tag));
	assign cap_eff     = (int'(cap_q) > POOL_DEPTH) ? CAP_BITS'(POOL_DEPTH) : cap_q;
	assign has_room    = CMP_W'(count_q) < CMP_W'(cap_eff);
	assign beats_worst = (count_q != '0) && (score_sat < worst_score_q);
	assign pick_start  = (offer_q < act_q) || (count_q == '0);

	bksp_mod #(
		.NW(CNT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (random_word),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		state_d   = state_q;
		in_stall  = (state_q != ST_IDLE);
		wr_en     = 1'b0;
		wr_addr   = count_q[AW-1:0];
		rd_addr   = scan_cnt_q[AW-1:0];
		mod_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_ADD: begin
							if (has_room) begin
								wr_en   = 1'b1;
								state_d = ST_FINISH;
							end else if (beats_worst) begin
								wr_en   = 1'b1;
								wr_addr = worst_slot_q;
								state_d = ST_SCAN;
							end else begin
								state_d = ST_FINISH;
							end
						end
						MODE_PICK: begin
							if (pick_start) begin
								state_d = ST_FINISH;
							end else begin
								mod_start = 1'b1;
								state_d   = ST_MOD;
							end
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == count_q - CNT_W'(1)) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: state_d = ST_FINISH;
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_PICK_RD;
				end
			end
			ST_PICK_RD: begin
				rd_addr = mod_rem[AW-1:0];
				state_d = ST_PICK_DATA;
			end
			ST_PICK_DATA: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q         <= CAP_RESET;
			act_q         <= '0;
			count_q       <= '0;
			worst_score_q <= '0;
			worst_slot_q  <= '0;
			offer_q       <= '0;
			outcome_q     <= OUT_NONE;
			pstart_q      <= 1'b0;
			ptag_q        <= '0;
			scan_cnt_q    <= '0;
			cmp_vld_s1    <= 1'b0;
			cmp_idx_s1    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY:   cap_q <= cfg_data[CAP_BITS-1:0];
					CFG_ACTIVATION: act_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_acc) begin
				ptag_q <= '0;
				case (mode)
					MODE_ADD: begin
						pstart_q <= 1'b0;
						if (offer_q != '1) begin
							offer_q <= offer_q + 1'b1;
						end
						if (has_room) begin
							count_q   <= count_q + 1'b1;
							outcome_q <= OUT_APPEND;
							if (count_q == '0 || score_sat > worst_score_q) begin
								worst_score_q <= score_sat;
								worst_slot_q  <= count_q[AW-1:0];
							end
						end else if (beats_worst) begin
							outcome_q  <= OUT_REPLACE;
							scan_cnt_q <= '0;
						end else begin
							outcome_q <= OUT_REJECT;
						end
					end
					MODE_PICK: begin
						outcome_q <= OUT_NONE;
						pstart_q  <= pick_start;
					end
					MODE_CLEAR: begin
						outcome_q     <= OUT_NONE;
						pstart_q      <= 1'b0;
						count_q       <= '0;
						worst_score_q <= '0;
						worst_slot_q  <= '0;
						offer_q       <= '0;
					end
					default: begin
						outcome_q <= OUT_NONE;
						pstart_q  <= 1'b0;
					end
				endcase
			end

			// rescan: compare stage trails the read address, acting in the cycle after it
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= scan_cnt_q[AW-1:0];
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (cmp_vld_s1) begin
				if (cmp_idx_s1 == '0 || score_rd_q > worst_score_q) begin
					worst_score_q <= score_rd_q;
					worst_slot_q  <= cmp_idx_s1;
				end
			end

			if (state_q == ST_PICK_DATA) begin
				ptag_q <= tag_rd_q;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			add_outcome_q  <= outcome_q;
			picked_tag_q   <= FIELD_BITS'(32'(ptag_q));
			picked_start_q <= pstart_q;
			occupancy_q    <= OCC_BITS'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			score_mem[wr_addr] <= score_sat;
			tag_mem[wr_addr]   <= tag_in;
		end
		score_rd_q <= score_mem[rd_addr];
		tag_rd_q   <= tag_mem[rd_addr];
	end

	assign out_valid    = out_valid_q;
	assign add_outcome  = add_outcome_q;
	assign picked_tag   = picked_tag_q;
	assign picked_start = picked_start_q;
	assign occupancy    = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= POOL_DEPTH)
		else $error("pool count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode == MODE_ADD && has_room) |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not grow the pool");

	a_mod_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_MOD)
		else $error("remainder done outside pick");

	a_worst_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q != '0) |-> CNT_W'(worst_slot_q) < count_q)
		else $error("worst slot outside occupied range");

endmodule

// File: hdl/bksp_mod.sv
// bksp_mod: iterative restoring remainder unit, one dividend bit per cycle.
// Depends on bksp_pkg for the dividend width.
`timescale 1ns / 1ps

module bksp_mod #(
	parameter int NW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bksp_pkg::RND_BITS-1:0] dividend,
	input  logic [NW-1:0]                 divisor,
	output logic                          done,
	output logic [NW-1:0]                 rem
);
	import bksp_pkg::*;

	localparam int CW = $clog2(RND_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [RND_BITS-1:0] dvd_q;
	logic [NW-1:0]       dvs_q;
	logic [NW-1:0]       rem_q;
	logic [NW:0]         trial;
	logic [NW-1:0]       rem_nxt;

	assign trial   = {rem_q, dvd_q[RND_BITS-1]};
	assign rem_nxt = (trial >= {1'b0, dvs_q}) ? NW'(trial - {1'b0, dvs_q}) : NW'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RND_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
